// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Screen geometry, control codes and the command record that passes from
// the front end to the engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int TEXT_COLS  = 80;
  localparam int TEXT_ROWS  = 25;
  localparam int CELL_COUNT = TEXT_COLS * TEXT_ROWS;

  localparam int ADDR_W = 11;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int WORD_W = 16;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h0F;

  localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_COPY   = ADDR_W'(CELL_COUNT - TEXT_COLS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_ROW0 = ADDR_W'(CELL_COUNT - TEXT_COLS);
  localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(TEXT_COLS);
  localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(TEXT_ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(TEXT_COLS - 1);

  typedef enum logic [2:0] {
    K_PUT,
    K_LF,
    K_CR,
    K_CLEAR,
    K_READ,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        code;
    logic [ADDR_W-1:0] index;
    logic              index_ok;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front: request intake and classification
// Decodes each request into a command and holds up to two in a small queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [1:0]                 mode,
  input  wire logic [7:0]                 code_byte,
  input  wire logic [tcw_pkg::ADDR_W-1:0] cell_index,
  input  wire tcw_pkg::stat_t             stat,
  output logic                            cmd_valid,
  output tcw_pkg::cmd_t                   cmd,
  input  wire logic                       cmd_take
);

  tcw_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  tcw_pkg::cmd_t in_cmd;
  logic          do_push;

  // Classify the request on the way in
  always_comb begin
    in_cmd.code     = code_byte;
    in_cmd.index    = cell_index;
    in_cmd.index_ok = (cell_index <= tcw_pkg::LAST_CELL);
    unique case (mode)
      tcw_pkg::MODE_PUT: begin
        if (code_byte == tcw_pkg::CH_LF) begin
          in_cmd.kind = tcw_pkg::K_LF;
        end else if (code_byte == tcw_pkg::CH_CR) begin
          in_cmd.kind = tcw_pkg::K_CR;
        end else begin
          in_cmd.kind = tcw_pkg::K_PUT;
        end
      end
      tcw_pkg::MODE_CLEAR: in_cmd.kind = tcw_pkg::K_CLEAR;
      tcw_pkg::MODE_READ:  in_cmd.kind = tcw_pkg::K_READ;
      default:             in_cmd.kind = tcw_pkg::K_NOP;
    endcase
  end

  assign full      = (count == 2'd2) || stat.init_busy;
  assign do_push   = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, cmd_take};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tcw_engine.sv =====
// ----------------------------------------------------------------------------
// tcw_engine: command execution on the cell store
// Owns the cell memory and the cursor, runs writes, reads, scroll and clear
// sweeps, and holds one finished result for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_engine (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cmd_valid,
  input  wire tcw_pkg::cmd_t               cmd,
  output logic                             cmd_take,
  output tcw_pkg::stat_t                   stat,
  input  wire logic [7:0]                  text_attribute,
  input  wire logic                        pop,
  output logic                             empty,
  output logic [tcw_pkg::ADDR_W-1:0]       cursor_pos,
  output logic [tcw_pkg::ROW_W-1:0]        cursor_row,
  output logic [tcw_pkg::COL_W-1:0]        cursor_col,
  output logic [tcw_pkg::WORD_W-1:0]       cell_word,
  output logic                             scrolled
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_COPY  = 4'b0100,
    S_SWEEP = 4'b1000
  } state_t;

  state_t                        state, state_next;
  logic [tcw_pkg::ROW_W-1:0]     cur_row, cur_row_next;
  logic [tcw_pkg::COL_W-1:0]     cur_col, cur_col_next;
  logic [tcw_pkg::ADDR_W-1:0]    cur_pos, cur_pos_next;
  logic [tcw_pkg::ADDR_W-1:0]    cnt, cnt_next;
  logic [tcw_pkg::WORD_W-1:0]    fill, fill_next;
  logic                          init_pass, init_pass_next;
  logic                          scr, scr_next;
  logic                          pend, pend_next;
  logic [tcw_pkg::ADDR_W-1:0]    pend_addr, pend_addr_next;
  logic                          res_valid, res_valid_next;
  logic                          res_load;
  logic [tcw_pkg::WORD_W-1:0]    res_word_val;
  logic                          res_scr_val;

  logic [tcw_pkg::WORD_W-1:0]    mem [tcw_pkg::CELL_COUNT];
  logic                          we;
  logic [tcw_pkg::ADDR_W-1:0]    waddr;
  logic [tcw_pkg::WORD_W-1:0]    wdata;
  logic [tcw_pkg::ADDR_W-1:0]    raddr;
  logic [tcw_pkg::WORD_W-1:0]    rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next     = state;
    cur_row_next   = cur_row;
    cur_col_next   = cur_col;
    cur_pos_next   = cur_pos;
    cnt_next       = cnt;
    fill_next      = fill;
    init_pass_next = init_pass;
    scr_next       = scr;
    pend_next      = 1'b0;
    pend_addr_next = pend_addr;
    cmd_take       = 1'b0;
    res_load       = 1'b0;
    res_word_val   = '0;
    res_scr_val    = 1'b0;
    we             = 1'b0;
    waddr          = cnt;
    wdata          = fill;
    raddr          = cmd.index;

    // Finish the copy write whose source word was read last cycle
    if (pend) begin
      we    = 1'b1;
      waddr = pend_addr;
      wdata = rdata;
    end

    unique case (state)
      S_IDLE: begin
        if (cmd_valid && !res_valid) begin
          cmd_take = 1'b1;
          case (cmd.kind)
            tcw_pkg::K_PUT: begin
              we    = 1'b1;
              waddr = cur_pos;
              wdata = {text_attribute, cmd.code};
              if (cur_col == tcw_pkg::LAST_COL) begin
                cur_col_next = '0;
                if (cur_row == tcw_pkg::LAST_ROW) begin
                  cur_pos_next = tcw_pkg::BOTTOM_ROW0;
                  cnt_next     = '0;
                  scr_next     = 1'b1;
                  state_next   = S_COPY;
                end else begin
                  cur_row_next = cur_row + 1'b1;
                  cur_pos_next = cur_pos + 1'b1;
                  res_load     = 1'b1;
                end
              end else begin
                cur_col_next = cur_col + 1'b1;
                cur_pos_next = cur_pos + 1'b1;
                res_load     = 1'b1;
              end
            end
            tcw_pkg::K_LF: begin
              cur_col_next = '0;
              if (cur_row == tcw_pkg::LAST_ROW) begin
                cur_pos_next = tcw_pkg::BOTTOM_ROW0;
                cnt_next     = '0;
                scr_next     = 1'b1;
                state_next   = S_COPY;
              end else begin
                cur_row_next = cur_row + 1'b1;
                cur_pos_next = cur_pos - tcw_pkg::ADDR_W'(cur_col) + tcw_pkg::COLS_A;
                res_load     = 1'b1;
              end
            end
            tcw_pkg::K_CR: begin
              cur_col_next = '0;
              cur_pos_next = cur_pos - tcw_pkg::ADDR_W'(cur_col);
              res_load     = 1'b1;
            end
            tcw_pkg::K_CLEAR: begin
              cur_row_next = '0;
              cur_col_next = '0;
              cur_pos_next = '0;
              cnt_next     = '0;
              fill_next    = {text_attribute, cmd.code};
              scr_next     = 1'b0;
              state_next   = S_SWEEP;
            end
            tcw_pkg::K_READ: begin
              if (cmd.index_ok) begin
                state_next = S_READ;
              end else begin
                res_load = 1'b1;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        res_load     = 1'b1;
        res_word_val = rdata;
        state_next   = S_IDLE;
      end
      S_COPY: begin
        raddr          = cnt + tcw_pkg::COLS_A;
        pend_next      = 1'b1;
        pend_addr_next = cnt;
        if (cnt == tcw_pkg::LAST_COPY) begin
          cnt_next   = tcw_pkg::BOTTOM_ROW0;
          fill_next  = {text_attribute, tcw_pkg::CH_SPACE};
          state_next = S_SWEEP;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SWEEP: begin
        if (!pend) begin
          we = 1'b1;
          if (cnt == tcw_pkg::LAST_CELL) begin
            state_next = S_IDLE;
            if (init_pass) begin
              init_pass_next = 1'b0;
            end else begin
              res_load    = 1'b1;
              res_scr_val = scr;
            end
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (res_load) begin
      res_valid_next = 1'b1;
    end else if (pop && res_valid) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      cur_row   <= '0;
      cur_col   <= '0;
      cur_pos   <= '0;
      cnt       <= '0;
      fill      <= {tcw_pkg::RESET_ATTR, tcw_pkg::CH_SPACE};
      init_pass <= 1'b1;
      scr       <= 1'b0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_row   <= cur_row_next;
      cur_col   <= cur_col_next;
      cur_pos   <= cur_pos_next;
      cnt       <= cnt_next;
      fill      <= fill_next;
      init_pass <= init_pass_next;
      scr       <= scr_next;
      pend      <= pend_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= pend_addr_next;
    if (res_load) begin
      cursor_pos <= cur_pos_next;
      cursor_row <= cur_row_next;
      cursor_col <= cur_col_next;
      cell_word  <= res_word_val;
      scrolled   <= res_scr_val;
    end
  end

  assign empty          = !res_valid;
  assign stat.init_busy = init_pass;

  // Cursor stays on screen and the linear position tracks row and column
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cur_row <= tcw_pkg::LAST_ROW) && (cur_col <= tcw_pkg::LAST_COL))
    else $error("cursor left the screen");

  a_cursor_pos: assert property (@(posedge clk) disable iff (rst)
    32'(cur_pos) == 32'(cur_row) * tcw_pkg::TEXT_COLS + 32'(cur_col))
    else $error("linear cursor position out of step");

  a_take_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> !res_valid && (state == S_IDLE))
    else $error("command taken while busy or result waiting");

  a_pend_in_scroll: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_COPY) || (state == S_SWEEP))
    else $error("copy write pending outside scroll");

  a_no_take_init: assert property (@(posedge clk) disable iff (rst)
    init_pass |-> !cmd_take)
    else $error("command taken during reset clearing pass");

endmodule

`default_nettype wire

// ===== rtl/core/text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_core: 80x25 text console engine
// Writes characters into a cell store with cursor tracking, scrolling,
// screen clear and single-cell readback.
// Requests: drive mode, code_byte and cell_index and raise push; a request
//   is taken on an edge where push is high and full is low. The front end
//   decodes it and parks up to two requests while the engine is busy.
// Results: while empty is low the result ports carry the oldest result and
//   pop takes it; one result per request. A stalled result holds and the
//   engine waits on it; the front queue keeps taking requests until full.
// Sequence: put, line feed (unless they scroll), carriage return and mode 3
//   load their result when taken; a read first passes the registered read
//   port. A scroll copies each row below the top up one row, finishes the
//   last copy write and blanks the bottom row. A clear fills every cell. A
//   new request is taken only when the engine is idle and no result waits.
// Reset: the cursor homes and a clearing pass writes a space with attribute
//   0x0F into all 2000 cells, one per cycle, with full high throughout the
//   pass. text_attribute resets to 0x0F; write it over APB only while the
//   engine is idle with no request in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // request side
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [1:0]                  mode,
  input  wire logic [7:0]                  code_byte,
  input  wire logic [tcw_pkg::ADDR_W-1:0]  cell_index,
  // result side
  input  wire logic                        pop,
  output logic                             empty,
  output logic [tcw_pkg::ADDR_W-1:0]       cursor_pos,
  output logic [tcw_pkg::ROW_W-1:0]        cursor_row,
  output logic [tcw_pkg::COL_W-1:0]        cursor_col,
  output logic [tcw_pkg::WORD_W-1:0]       cell_word,
  output logic                             scrolled,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  // Register 0 (text_attribute) sits at byte address 0; paddr[2] selects
  // the register index.
  logic [7:0]     text_attribute;
  logic           cfg_wr;

  logic           cmd_valid;
  tcw_pkg::cmd_t  cmd;
  logic           cmd_take;
  tcw_pkg::stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];

  // Hold the attribute byte; only the low byte of the write data counts
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= tcw_pkg::RESET_ATTR;
    end else if (cfg_wr) begin
      text_attribute <= pwdata[7:0];
    end
  end

  // Read back the attribute, zero for addresses beyond the register list
  always_comb begin
    if (!paddr[2]) begin
      prdata = {24'd0, text_attribute};
    end else begin
      prdata = '0;
    end
  end

  // Front end: take requests, classify them, queue them
  tcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .mode       (mode),
    .code_byte  (code_byte),
    .cell_index (cell_index),
    .stat       (stat),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  // Back end: carry commands out on the cell store and drive results
  tcw_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_take       (cmd_take),
    .stat           (stat),
    .text_attribute (text_attribute),
    .pop            (pop),
    .empty          (empty),
    .cursor_pos     (cursor_pos),
    .cursor_row     (cursor_row),
    .cursor_col     (cursor_col),
    .cell_word      (cell_word),
    .scrolled       (scrolled)
  );

endmodule

`default_nettype wire
